/* sv/md2_pkg.sv */
// shared types, constants and substitution table for the md2 digest engine
package md2_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int STATE_BYTES = 48;

  localparam logic [5:0] STEP_LAST  = 6'(STATE_BYTES - 1);
  localparam logic [5:0] BLOCK_LAST = 6'(BLOCK_BYTES - 1);
  localparam logic [4:0] ROUND_LAST = 5'd17;
  localparam logic [3:0] FILL_LAST  = 4'(BLOCK_BYTES - 1);
  localparam logic [4:0] BLOCK_LEN  = 5'(BLOCK_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_SETUP,
    ST_ROUNDS,
    ST_CKS,
    ST_COPY,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD,
    BLK_SUM
  } blk_t;

  typedef struct packed {
    logic       buf_shift;
    logic       buf_pad;
    logic [7:0] pad;
    logic       buf_copy;
    logic       setup;
    logic       hash_step;
    logic       round_end;
    logic [4:0] round;
    logic       cks_load;
    logic       cks_step;
    logic       emit_shift;
    logic       clear;
  } ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h29, 8'h2E, 8'h43, 8'hC9, 8'hA2, 8'hD8, 8'h7C, 8'h01, 8'h3D, 8'h36, 8'h54, 8'hA1,
    8'hEC, 8'hF0, 8'h06, 8'h13, 8'h62, 8'hA7, 8'h05, 8'hF3, 8'hC0, 8'hC7, 8'h73, 8'h8C,
    8'h98, 8'h93, 8'h2B, 8'hD9, 8'hBC, 8'h4C, 8'h82, 8'hCA, 8'h1E, 8'h9B, 8'h57, 8'h3C,
    8'hFD, 8'hD4, 8'hE0, 8'h16, 8'h67, 8'h42, 8'h6F, 8'h18, 8'h8A, 8'h17, 8'hE5, 8'h12,
    8'hBE, 8'h4E, 8'hC4, 8'hD6, 8'hDA, 8'h9E, 8'hDE, 8'h49, 8'hA0, 8'hFB, 8'hF5, 8'h8E,
    8'hBB, 8'h2F, 8'hEE, 8'h7A, 8'hA9, 8'h68, 8'h79, 8'h91, 8'h15, 8'hB2, 8'h07, 8'h3F,
    8'h94, 8'hC2, 8'h10, 8'h89, 8'h0B, 8'h22, 8'h5F, 8'h21, 8'h80, 8'h7F, 8'h5D, 8'h9A,
    8'h5A, 8'h90, 8'h32, 8'h27, 8'h35, 8'h3E, 8'hCC, 8'hE7, 8'hBF, 8'hF7, 8'h97, 8'h03,
    8'hFF, 8'h19, 8'h30, 8'hB3, 8'h48, 8'hA5, 8'hB5, 8'hD1, 8'hD7, 8'h5E, 8'h92, 8'h2A,
    8'hAC, 8'h56, 8'hAA, 8'hC6, 8'h4F, 8'hB8, 8'h38, 8'hD2, 8'h96, 8'hA4, 8'h7D, 8'hB6,
    8'h76, 8'hFC, 8'h6B, 8'hE2, 8'h9C, 8'h74, 8'h04, 8'hF1, 8'h45, 8'h9D, 8'h70, 8'h59,
    8'h64, 8'h71, 8'h87, 8'h20, 8'h86, 8'h5B, 8'hCF, 8'h65, 8'hE6, 8'h2D, 8'hA8, 8'h02,
    8'h1B, 8'h60, 8'h25, 8'hAD, 8'hAE, 8'hB0, 8'hB9, 8'hF6, 8'h1C, 8'h46, 8'h61, 8'h69,
    8'h34, 8'h40, 8'h7E, 8'h0F, 8'h55, 8'h47, 8'hA3, 8'h23, 8'hDD, 8'h51, 8'hAF, 8'h3A,
    8'hC3, 8'h5C, 8'hF9, 8'hCE, 8'hBA, 8'hC5, 8'hEA, 8'h26, 8'h2C, 8'h53, 8'h0D, 8'h6E,
    8'h85, 8'h28, 8'h84, 8'h09, 8'hD3, 8'hDF, 8'hCD, 8'hF4, 8'h41, 8'h81, 8'h4D, 8'h52,
    8'h6A, 8'hDC, 8'h37, 8'hC8, 8'h6C, 8'hC1, 8'hAB, 8'hFA, 8'h24, 8'hE1, 8'h7B, 8'h08,
    8'h0C, 8'hBD, 8'hB1, 8'h4A, 8'h78, 8'h88, 8'h95, 8'h8B, 8'hE3, 8'h63, 8'hE8, 8'h6D,
    8'hE9, 8'hCB, 8'hD5, 8'hFE, 8'h3B, 8'h00, 8'h1D, 8'h39, 8'hF2, 8'hEF, 8'hB7, 8'h0E,
    8'h66, 8'h58, 8'hD0, 8'hE4, 8'hA6, 8'h77, 8'h72, 8'hF8, 8'hEB, 8'h75, 8'h4B, 8'h0A,
    8'h31, 8'h44, 8'h50, 8'hB4, 8'h8F, 8'hED, 8'h1F, 8'h1A, 8'hDB, 8'h99, 8'h8D, 8'h33,
    8'h9F, 8'h11, 8'h83, 8'h14
  };

endpackage

/* sv/md2_hash_engine_unit.sv */
// md2 digest engine top level: state, checksum and block registers around the shared unit
// Message bytes arrive one per transaction; in_tuser marks a byte as present and in_tlast ends
// the message. A byte that does not complete a block is taken while idle. The sixteenth byte
// of a block starts a compression (1 setup step, 18 x 48 substitution steps, 16
// checksum steps), all through one substitution lookup per cycle, and no transaction is taken
// meanwhile. An end marker adds padding (1 to 16 bytes), the padded block, a copy step and
// the checksum block, then 16 digest bytes leave on the out_ channel, the last with out_tlast,
// after which a new message may begin.
module md2_hash_engine_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // message_byte
  input  logic       in_tuser,   // byte_present
  input  logic       in_tlast,   // message_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // digest_byte
  output logic       out_tlast   // last_byte
);

  md2_pkg::ctl_t ctl;
  logic [7:0]    h_r   [md2_pkg::STATE_BYTES];
  logic [7:0]    h_nxt [md2_pkg::STATE_BYTES];
  logic [7:0]    cks_r   [md2_pkg::BLOCK_BYTES];
  logic [7:0]    cks_nxt [md2_pkg::BLOCK_BYTES];
  logic [7:0]    buf_r   [md2_pkg::BLOCK_BYTES];
  logic [7:0]    buf_nxt [md2_pkg::BLOCK_BYTES];
  logic [7:0]    t_r, t_nxt;
  logic [7:0]    unit_a, unit_b, unit_y;

  md2_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_present (in_tuser),
    .in_end     (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .ctl        (ctl)
  );

  md2_sbox_unit u_sbox (
    .a_i (unit_a),
    .b_i (unit_b),
    .y_o (unit_y)
  );

  assign unit_a    = ctl.cks_step ? cks_r[0] : h_r[0];
  assign unit_b    = ctl.cks_step ? (buf_r[0] ^ t_r) : t_r;
  assign out_tdata = h_r[0];

  always_comb begin
    h_nxt   = h_r;
    cks_nxt = cks_r;
    buf_nxt = buf_r;
    t_nxt   = t_r;
    if (ctl.buf_shift) begin
      for (int i = 0; i < md2_pkg::BLOCK_BYTES - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      buf_nxt[md2_pkg::BLOCK_BYTES-1] = ctl.buf_pad ? ctl.pad : in_tdata;
    end
    if (ctl.buf_copy) begin
      buf_nxt = cks_r;
    end
    if (ctl.setup) begin
      for (int i = 0; i < md2_pkg::BLOCK_BYTES; i++) begin
        h_nxt[i+16] = buf_r[i];
        h_nxt[i+32] = buf_r[i] ^ h_r[i];
      end
      t_nxt = '0;
    end
    if (ctl.hash_step || ctl.emit_shift) begin
      for (int i = 0; i < md2_pkg::STATE_BYTES - 1; i++) begin
        h_nxt[i] = h_r[i+1];
      end
      h_nxt[md2_pkg::STATE_BYTES-1] = ctl.hash_step ? unit_y : h_r[0];
    end
    if (ctl.hash_step) begin
      t_nxt = ctl.round_end ? unit_y + {3'b000, ctl.round} : unit_y;
    end
    if (ctl.cks_load) begin
      t_nxt = cks_r[md2_pkg::BLOCK_BYTES-1];
    end
    if (ctl.cks_step) begin
      for (int i = 0; i < md2_pkg::BLOCK_BYTES - 1; i++) begin
        cks_nxt[i] = cks_r[i+1];
        buf_nxt[i] = buf_r[i+1];
      end
      cks_nxt[md2_pkg::BLOCK_BYTES-1] = unit_y;
      buf_nxt[md2_pkg::BLOCK_BYTES-1] = buf_r[0];
      t_nxt = unit_y;
    end
    if (ctl.clear) begin
      for (int i = 0; i < md2_pkg::STATE_BYTES; i++) begin
        h_nxt[i] = '0;
      end
      for (int i = 0; i < md2_pkg::BLOCK_BYTES; i++) begin
        cks_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < md2_pkg::STATE_BYTES; i++) begin
        h_r[i] <= '0;
      end
      for (int i = 0; i < md2_pkg::BLOCK_BYTES; i++) begin
        cks_r[i] <= '0;
      end
    end else begin
      h_r   <= h_nxt;
      cks_r <= cks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    t_r   <= t_nxt;
  end

endmodule

/* sv/md2_sbox_unit.sv */
// shared substitution unit: xor of an operand with a table lookup
module md2_sbox_unit (
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  output logic [7:0] y_o
);

  assign y_o = a_i ^ md2_pkg::SBOX[b_i];

endmodule

/* sv/md2_seq.sv */
// sequencer: input handling, padding, round and step counters, digest output control
module md2_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_present,
  input  logic          in_end,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic          out_tlast,
  output md2_pkg::ctl_t ctl
);

  md2_pkg::state_t state_r, state_nxt;
  md2_pkg::blk_t   kind_r, kind_nxt;
  logic [3:0]      fill_r, fill_nxt;
  logic [7:0]      pad_r, pad_nxt;
  logic [5:0]      step_r, step_nxt;
  logic [4:0]      round_r, round_nxt;
  logic            end_pend_r, end_pend_nxt;
  logic [3:0]      fill_after;
  logic            in_fire;
  logic            out_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= md2_pkg::ST_IDLE;
      kind_r     <= md2_pkg::BLK_DATA;
      fill_r     <= '0;
      pad_r      <= '0;
      step_r     <= '0;
      round_r    <= '0;
      end_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      kind_r     <= kind_nxt;
      fill_r     <= fill_nxt;
      pad_r      <= pad_nxt;
      step_r     <= step_nxt;
      round_r    <= round_nxt;
      end_pend_r <= end_pend_nxt;
    end
  end

  assign in_tready  = (state_r == md2_pkg::ST_IDLE);
  assign out_tvalid = (state_r == md2_pkg::ST_EMIT);
  assign out_tlast  = out_tvalid && (step_r == md2_pkg::BLOCK_LAST);
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_tvalid && out_tready;
  assign fill_after = in_present ? fill_r + 4'd1 : fill_r;

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    fill_nxt     = fill_r;
    pad_nxt      = pad_r;
    step_nxt     = step_r;
    round_nxt    = round_r;
    end_pend_nxt = end_pend_r;
    ctl          = '0;
    ctl.pad      = pad_r;
    ctl.round    = round_r;
    case (state_r)
      md2_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_present) begin
            ctl.buf_shift = 1'b1;
            fill_nxt      = fill_after;
          end
          if (in_present && fill_r == md2_pkg::FILL_LAST) begin
            kind_nxt     = md2_pkg::BLK_DATA;
            end_pend_nxt = in_end;
            state_nxt    = md2_pkg::ST_SETUP;
          end else if (in_end) begin
            pad_nxt   = {3'b000, md2_pkg::BLOCK_LEN - {1'b0, fill_after}};
            state_nxt = md2_pkg::ST_PAD;
          end
        end
      end
      md2_pkg::ST_PAD: begin
        ctl.buf_shift = 1'b1;
        ctl.buf_pad   = 1'b1;
        fill_nxt      = fill_r + 4'd1;
        if (fill_r == md2_pkg::FILL_LAST) begin
          kind_nxt  = md2_pkg::BLK_PAD;
          state_nxt = md2_pkg::ST_SETUP;
        end
      end
      md2_pkg::ST_SETUP: begin
        ctl.setup = 1'b1;
        step_nxt  = '0;
        round_nxt = '0;
        state_nxt = md2_pkg::ST_ROUNDS;
      end
      md2_pkg::ST_ROUNDS: begin
        ctl.hash_step = 1'b1;
        if (step_r == md2_pkg::STEP_LAST) begin
          step_nxt      = '0;
          ctl.round_end = 1'b1;
          if (round_r == md2_pkg::ROUND_LAST) begin
            round_nxt = '0;
            if (kind_r == md2_pkg::BLK_SUM) begin
              state_nxt = md2_pkg::ST_EMIT;
            end else begin
              ctl.cks_load = 1'b1;
              state_nxt    = md2_pkg::ST_CKS;
            end
          end else begin
            round_nxt = round_r + 5'd1;
          end
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      md2_pkg::ST_CKS: begin
        ctl.cks_step = 1'b1;
        if (step_r == md2_pkg::BLOCK_LAST) begin
          step_nxt = '0;
          if (kind_r == md2_pkg::BLK_PAD) begin
            state_nxt = md2_pkg::ST_COPY;
          end else if (end_pend_r) begin
            end_pend_nxt = 1'b0;
            pad_nxt      = {3'b000, md2_pkg::BLOCK_LEN};
            state_nxt    = md2_pkg::ST_PAD;
          end else begin
            state_nxt = md2_pkg::ST_IDLE;
          end
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      md2_pkg::ST_COPY: begin
        ctl.buf_copy = 1'b1;
        kind_nxt     = md2_pkg::BLK_SUM;
        state_nxt    = md2_pkg::ST_SETUP;
      end
      md2_pkg::ST_EMIT: begin
        if (out_fire) begin
          ctl.emit_shift = 1'b1;
          if (step_r == md2_pkg::BLOCK_LAST) begin
            step_nxt  = '0;
            fill_nxt  = '0;
            ctl.clear = 1'b1;
            state_nxt = md2_pkg::ST_IDLE;
          end else begin
            step_nxt = step_r + 6'd1;
          end
        end
      end
      default: begin
        state_nxt = md2_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while digest pending");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("no return to idle after last digest byte");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    round_r <= md2_pkg::ROUND_LAST && step_r <= md2_pkg::STEP_LAST)
    else $error("round or step counter out of range");

  a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> fill_r == 4'd0 && !end_pend_r)
    else $error("block buffer not empty during digest output");

  a_sum_block: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == md2_pkg::ST_ROUNDS) && kind_r == md2_pkg::BLK_SUM)
    else $error("digest output not after checksum block");
`endif

endmodule
